FILE: src/sbsd_pkg.sv
// Shared types, constants and decode helpers of the signer bitmap stream decoder.
package sbsd_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned POS_W       = 17;
   localparam int unsigned COVER_W     = 18;
   localparam int unsigned SIZE_W      = 4;
   localparam int unsigned MAX_BITS    = 2048;
   localparam int unsigned HDR_BYTES   = 3;
   localparam int unsigned BITMAP_PER  = 8;
   localparam int unsigned TRIT_PER    = 5;
   localparam int unsigned TRIT_DIGITS = 5;

   localparam logic [POS_W-1:0]   POS_TOP   = {POS_W{1'b1}};
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BITS);

   localparam logic [DATA_W-1:0] VERSION_BITMAP = 8'd0;
   localparam logic [DATA_W-1:0] VERSION_TRIT   = 8'd1;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SIZE    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic {
      KIND_GROUP  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic {
      FORMAT_BITMAP = 1'b0,
      FORMAT_TRIT   = 1'b1
   } format_type;

   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic [DATA_W-1:0]  version;
      logic [COUNT_W-1:0] declared;
      logic [COVER_W-1:0] covered;
   } frame_state_type;

   typedef struct packed {
      kind_type           result_kind;
      logic [COUNT_W-1:0] first_bit;
      logic [DATA_W-1:0]  primary_bits;
      logic [DATA_W-1:0]  fallback_bits;
      logic [SIZE_W-1:0]  group_size;
      status_type         status;
      format_type         format;
      logic               last;
   } result_type;

   // up to two results per request, first one written first
   typedef struct packed {
      logic [1:0] push_count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic [TRIT_DIGITS-1:0] prim;
      logic [TRIT_DIGITS-1:0] fb;
   } trit_masks_type;

   // Mask of the low 'size' bits, size 0..8.
   function automatic logic [DATA_W-1:0] low_mask(input logic [SIZE_W-1:0] size);
      logic [DATA_W-1:0] ones;
      ones = '1;
      return ones >> (SIZE_W'(DATA_W) - size);
   endfunction

   // Splits a byte into base-3 digits, most significant first, by compare and subtract.
   // Bytes above 242 leave a top digit of 3, which marks neither set.
   function automatic trit_masks_type trit_split(input logic [DATA_W-1:0] value,
                                                 input logic [SIZE_W-1:0] size);
      logic [9:0]     rest;
      logic [9:0]     weight;
      logic [1:0]     digit;
      trit_masks_type masks;
      rest  = 10'(value);
      masks = '0;
      for (int i = TRIT_DIGITS - 1; i >= 0; i--) begin
         weight = 10'(3 ** i);
         if (rest >= 10'(3) * weight) begin
            digit = 2'd3;
            rest  = rest - 10'(3) * weight;
         end else if (rest >= 10'(2) * weight) begin
            digit = 2'd2;
            rest  = rest - 10'(2) * weight;
         end else if (rest >= weight) begin
            digit = 2'd1;
            rest  = rest - weight;
         end else begin
            digit = 2'd0;
         end
         masks.prim[i] = (digit == 2'd1) && (SIZE_W'(i) < size);
         masks.fb[i]   = (digit == 2'd2) && (SIZE_W'(i) < size);
      end
      return masks;
   endfunction

endpackage

FILE: src/sbsd_req_if.sv
// Request channel: one buffer byte per handshake.
interface sbsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

FILE: src/sbsd_rsp_if.sv
// Result channel: one group or status result per handshake.
interface sbsd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] first_bit;
   logic [7:0]  primary_bits;
   logic [7:0]  fallback_bits;
   logic [3:0]  group_size;
   logic [1:0]  status;
   logic        format;
   logic        last;

   modport source (output valid, result_kind, first_bit, primary_bits, fallback_bits,
                   group_size, status, format, last, input ready);
   modport sink   (input valid, result_kind, first_bit, primary_bits, fallback_bits,
                   group_size, status, format, last, output ready);
endinterface

FILE: src/sbsd_frame_decode.sv
// Frame state registers and single-pass decode of one buffer byte.
module sbsd_frame_decode #(
   parameter int unsigned MAX_BITS = sbsd_pkg::MAX_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [7:0]                     data_byte,
   input  logic                           last_byte,
   input  logic                           pair_mode,
   output sbsd_pkg::push_type             push
);
   import sbsd_pkg::*;

   localparam logic [COUNT_W-1:0] BIT_LIMIT = COUNT_W'(MAX_BITS);

   frame_state_type state_ff, state_in;

   logic [DATA_W-1:0]  version_now;
   logic [COUNT_W-1:0] declared_now;
   logic               is_trit;
   logic               version_ok;
   logic               payload;
   logic               size_ok;
   logic [SIZE_W-1:0]  per;
   logic [COVER_W-1:0] covered_sum;
   logic [COVER_W-1:0] covered_after;
   logic [COVER_W-1:0] declared_wide;
   logic               length_ok;
   logic               group_valid;
   logic [COUNT_W-1:0] remaining;
   logic [SIZE_W-1:0]  size;
   trit_masks_type     trits;
   result_type         group_res;
   result_type         status_res;

   always_comb begin
      // header bytes take effect in the step that carries them
      version_now  = (state_ff.pos == POS_W'(0)) ? data_byte : state_ff.version;
      declared_now = state_ff.declared;
      if (state_ff.pos == POS_W'(1)) begin
         declared_now[7:0] = data_byte;
      end else if (state_ff.pos == POS_W'(2)) begin
         declared_now[15:8] = data_byte;
      end

      is_trit    = (version_now == VERSION_TRIT);
      version_ok = (version_now == VERSION_BITMAP) || (is_trit && pair_mode);
      size_ok    = (declared_now <= BIT_LIMIT);
      per        = is_trit ? SIZE_W'(TRIT_PER) : SIZE_W'(BITMAP_PER);
      payload    = (state_ff.pos >= POS_W'(HDR_BYTES));

      covered_sum   = state_ff.covered + COVER_W'(per);
      covered_after = payload ? covered_sum : state_ff.covered;
      declared_wide = COVER_W'(declared_now);
      length_ok     = (covered_after >= declared_wide) &&
                      (covered_after < declared_wide + COVER_W'(per));

      group_valid = payload && version_ok && size_ok &&
                    (state_ff.covered < declared_wide);
      remaining   = declared_now - state_ff.covered[COUNT_W-1:0];
      size        = (remaining > COUNT_W'(per)) ? per : remaining[SIZE_W-1:0];
      trits       = trit_split(data_byte, size);

      group_res               = '0;
      group_res.result_kind   = KIND_GROUP;
      group_res.first_bit     = state_ff.covered[COUNT_W-1:0];
      group_res.group_size    = size;
      group_res.status        = STATUS_OK;
      group_res.format        = is_trit ? FORMAT_TRIT : FORMAT_BITMAP;
      group_res.last          = 1'b0;
      if (is_trit) begin
         group_res.primary_bits  = DATA_W'(trits.prim);
         group_res.fallback_bits = DATA_W'(trits.fb);
      end else begin
         group_res.primary_bits  = data_byte & low_mask(size);
         group_res.fallback_bits = '0;
      end

      status_res             = '0;
      status_res.result_kind = KIND_STATUS;
      status_res.last        = 1'b1;
      status_res.format      = FORMAT_BITMAP;
      priority if (state_ff.pos < POS_W'(HDR_BYTES - 1)) begin
         status_res.status = STATUS_SIZE;
      end else if (!version_ok) begin
         status_res.status = STATUS_INVALID;
      end else begin
         status_res.format = is_trit ? FORMAT_TRIT : FORMAT_BITMAP;
         priority if (!size_ok) begin
            status_res.status = STATUS_SIZE;
         end else if (!length_ok) begin
            status_res.status = STATUS_INVALID;
         end else begin
            status_res.status = STATUS_OK;
         end
      end

      push.push_count = accept ? (2'(group_valid) + 2'(last_byte)) : 2'd0;
      push.first      = group_valid ? group_res : status_res;
      push.second     = status_res;
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (last_byte) begin
            state_in = '0;
         end else begin
            state_in.version  = version_now;
            state_in.declared = declared_now;
            if (state_ff.pos != POS_TOP) begin
               state_in.pos = state_ff.pos + POS_W'(1);
            end
            // hold once far past any declared count
            if (payload && !state_ff.covered[COVER_W-1]) begin
               state_in.covered = covered_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/sbsd_rsp_queue.sv
// Small result queue taking up to two results per cycle, releasing up to one per cycle.
module sbsd_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  sbsd_pkg::push_type   push,
   input  logic                 pop,
   output logic                 has_space,
   output logic                 out_valid,
   output sbsd_pkg::result_type head
);
   import sbsd_pkg::*;

   result_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_next;

   assign has_space = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + QPTR_W'(1);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.push_count);
      count_in  = count_ff + QCNT_W'(push.push_count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.push_count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

FILE: src/signer_bitmap_stream_decoder_top.sv
// Top level of the signer bitmap stream decoder.
// Results of an accepted request are registered in the result queue and leave it on rsp.
// Throughput: one request per cycle; a closing byte adds a status result, so the
//   four-entry result queue sets the pace when rsp stalls or frames are very short.
// Reset (synchronous, active high) clears the frame state and the result queue
//   and sets pair_mode to 1; queued result payloads are not cleared.
module signer_bitmap_stream_decoder_top #(
   parameter int unsigned MAX_BITS = sbsd_pkg::MAX_BITS
) (
   input  logic           clock,
   input  logic           reset,
   sbsd_req_if.sink       req,
   sbsd_rsp_if.source     rsp,
   input  logic           csr_write_enable,
   input  logic           csr_write_data
);
   import sbsd_pkg::*;

   // pair_mode: 1 takes bitmap and trit frames, 0 bitmap frames only
   logic       pair_mode_ff, pair_mode_in;
   logic       req_accept;
   logic       rsp_pop;
   logic       has_space;
   push_type   push;
   result_type head;

   assign pair_mode_in = csr_write_enable ? csr_write_data : pair_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_mode_ff <= 1'b1;
      end else begin
         pair_mode_ff <= pair_mode_in;
      end
   end

   // A request may yield a group and a status, so two free queue slots are needed.
   assign req.ready  = has_space;
   assign req_accept = req.valid && has_space;
   assign rsp_pop    = rsp.valid && rsp.ready;

   // Header merge, group decode and status checks all happen in one pass
   // against the registered frame state.
   sbsd_frame_decode #(
      .MAX_BITS (MAX_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req.data_byte),
      .last_byte (req.last_byte),
      .pair_mode (pair_mode_ff),
      .push      (push)
   );

   // Results are registered here, which decouples rsp stalls from req.
   sbsd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_pop),
      .has_space (has_space),
      .out_valid (rsp.valid),
      .head      (head)
   );

   assign rsp.result_kind   = head.result_kind;
   assign rsp.first_bit     = head.first_bit;
   assign rsp.primary_bits  = head.primary_bits;
   assign rsp.fallback_bits = head.fallback_bits;
   assign rsp.group_size    = head.group_size;
   assign rsp.status        = head.status;
   assign rsp.format        = head.format;
   assign rsp.last          = head.last;

endmodule
